// ===== design/stereo_sine_waveshaper_assert.svh =====
// assertion macros for the stereo sine waveshaper
`ifndef STEREO_SINE_WAVESHAPER_ASSERT_SVH
`define STEREO_SINE_WAVESHAPER_ASSERT_SVH
`ifndef ASSERT_OFF
// checked only while out of reset
`define SSW_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define SSW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SSW_ASSERT(lbl, clk, rst_n, prop, msg)
`define SSW_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== design/ssw_pkg.sv =====
// shared constants, types and sine table function for the stereo sine waveshaper
package ssw_pkg;

	localparam int SAMPLE_BITS_DEF = 24;
	localparam int SINE_TABLE_BITS_DEF = 10;

	localparam int COEF_BITS = 17;
	localparam int GAIN_BITS = 20;
	localparam int CFG_IDX_BITS = 2;
	localparam int ANGLE_BITS = 32;
	localparam int INV_BITS = 30;
	localparam int TURN_LO = 24;
	localparam int TURN_BITS = 32;
	localparam int Q16_SH = 16;
	localparam int PIPE_DEPTH = 13;

	localparam logic [COEF_BITS-1:0] UNITY_Q16 = 17'd65536;
	localparam logic [COEF_BITS-1:0] DRIVE_RST = 17'd32768;
	localparam logic [COEF_BITS-1:0] LEVEL_RST = 17'd65536;
	localparam logic [COEF_BITS-1:0] WET_RST = 17'd65536;
	localparam logic [GAIN_BITS-1:0] GAIN_OFFSET_Q16 = 20'd104858;
	localparam logic [INV_BITS-1:0] INV_TWO_PI_Q32 = 30'd683565276;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [15:0] HALF_Q16 = 16'h8000;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_DRIVE = 2'd0,
		REG_LEVEL = 2'd1,
		REG_WET   = 2'd2
	} reg_idx_t;

	// coefficients as the datapath uses them
	typedef struct packed {
		logic [COEF_BITS-1:0] drive;
		logic [GAIN_BITS-1:0] gain;
		logic [COEF_BITS-1:0] level;
		logic [COEF_BITS-1:0] wet;
		logic [COEF_BITS-1:0] dry;
	} cfg_t;

	// sin(pi/2 * m / 2^qbits) in Q16, Q30 taylor series, elaboration only
	function automatic logic [COEF_BITS-1:0] quarter_sine(input int unsigned m,
			input int unsigned qbits);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic signed [63:0] sum;
		x = (HALF_PI_Q30 * 64'(m) + (64'd1 << (qbits - 1))) >> qbits;
		x2 = (x * x) >> 30;
		term = x;
		sum = $signed(x);
		term = ((term * x2) >> 30) / 64'd6;   sum = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd20;  sum = sum + $signed(term);
		term = ((term * x2) >> 30) / 64'd42;  sum = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd72;  sum = sum + $signed(term);
		term = ((term * x2) >> 30) / 64'd110; sum = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd156; sum = sum + $signed(term);
		term = ((term * x2) >> 30) / 64'd210; sum = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd272; sum = sum + $signed(term);
		term = ((term * x2) >> 30) / 64'd342; sum = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd420; sum = sum + $signed(term);
		term = ((term * x2) >> 30) / 64'd506; sum = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd600; sum = sum + $signed(term);
		if (sum < 0) begin
			sum = '0;
		end
		return COEF_BITS'(($unsigned(sum) + 64'd8192) >> 14);
	endfunction

endpackage

// ===== design/ssw_channel.sv =====
// one channel of the sine waveshaper, thirteen register stages
module ssw_channel #(
	parameter int SAMPLE_BITS = ssw_pkg::SAMPLE_BITS_DEF,
	parameter int SINE_TABLE_BITS = ssw_pkg::SINE_TABLE_BITS_DEF
) (
	input  logic                          clk,
	input  ssw_pkg::cfg_t                 cfg,
	input  logic signed [SAMPLE_BITS-1:0] x,
	output logic signed [SAMPLE_BITS-1:0] y
);
	import ssw_pkg::*;

	localparam int W = SAMPLE_BITS;
	localparam int F = W - 4;
	localparam int SB = SINE_TABLE_BITS;
	localparam int QBITS = SB - 2;
	localparam int QUARTER = 1 << QBITS;
	localparam int PA_BITS = W + GAIN_BITS;
	localparam int SQ_BITS = 2 * F + 2;
	localparam int TRIM_SH = 2 * F - 16;
	localparam int TP_BITS = ANGLE_BITS + INV_BITS;
	localparam int P1_BITS = 2 * COEF_BITS - 1;
	localparam int P2_BITS = P1_BITS + COEF_BITS;
	localparam int DEL_SH = 49 - F;
	localparam int LP_BITS = W + 19;
	localparam logic signed [LP_BITS-1:0] SAT_HI = (LP_BITS'(1) << (W - 1)) - LP_BITS'(1);
	localparam logic signed [LP_BITS-1:0] SAT_LO = -(LP_BITS'(1) << (W - 1));

	// quarter-wave sine table, entries 0 to QUARTER inclusive
	logic [COEF_BITS-1:0] qtab [QUARTER+1];

	for (genvar k = 0; k <= QUARTER; k++) begin : g_rom
		localparam logic [COEF_BITS-1:0] QV = quarter_sine(k, QBITS);
		assign qtab[k] = QV;
	end

	logic signed [W-1:0] x_s1, x_s2, x_s3, x_s4, x_s5, x_s6, x_s7, x_s8, x_s9, x_s10;
	logic [W-1:0]            t_s1;
	logic [ANGLE_BITS-1:0]   angle_s2;
	logic [SQ_BITS-1:0]      tsq_s2;
	logic                    tbig_s2;
	logic [SB-1:0]           idx_s3;
	logic [COEF_BITS-1:0]    trim_s3, trim_s4;
	logic [COEF_BITS-1:0]    smag_s4;
	logic                    sneg_s4, sneg_s5, sneg_s6, sneg_s7;
	logic [P1_BITS-1:0]      p1_s5;
	logic [P2_BITS-1:0]      p2_s6;
	logic [W-1:0]            dmag_s7;
	logic signed [W:0]       y_s8;
	logic signed [LP_BITS-1:0] lp_s9;
	logic signed [W:0]       yl_s10;
	logic signed [LP_BITS-1:0] wp_s11, dp_s11;
	logic signed [LP_BITS-1:0] sum_s12;
	logic signed [W-1:0]     y_s13;

	logic [PA_BITS-1:0]   pa;
	logic [SQ_BITS-1:0]   sq;
	logic [TP_BITS-1:0]   tp;
	logic [TURN_BITS-1:0] turn;
	logic [SQ_BITS-1:0]   trnd;
	logic [1:0]           quad;
	logic [QBITS-1:0]     rpos;
	logic [QBITS:0]       mpos;
	logic [P2_BITS-1:0]   p2r;
	logic signed [W:0]    xe;
	logic signed [W:0]    de;
	logic                 sub_d;
	logic [LP_BITS-1:0]   lr;
	logic [LP_BITS-1:0]   mr;
	logic signed [LP_BITS-1:0] yr;

	// s1: magnitude
	always_ff @(posedge clk) begin
		x_s1 <= x;
		t_s1 <= x[W-1] ? $unsigned(-x) : $unsigned(x);
	end

	// s2: angle = t * gain, and t squared for the trim
	assign pa = PA_BITS'(t_s1) * PA_BITS'(cfg.gain);
	assign sq = SQ_BITS'(t_s1[F:0]) * SQ_BITS'(t_s1[F:0]);

	always_ff @(posedge clk) begin
		angle_s2 <= pa[PA_BITS-1 -: ANGLE_BITS];
		tsq_s2   <= sq;
		tbig_s2  <= t_s1 > (W'(1) << F);
		x_s2     <= x_s1;
	end

	// s3: modulo two pi by scaling to turns, table index rounded
	assign tp = TP_BITS'(angle_s2) * TP_BITS'(INV_TWO_PI_Q32);
	assign turn = tp[TURN_LO +: TURN_BITS];
	assign trnd = tsq_s2 + (SQ_BITS'(1) << (TRIM_SH - 1));

	always_ff @(posedge clk) begin
		idx_s3  <= turn[TURN_BITS-1 -: SB] + SB'(turn[TURN_BITS-1-SB]);
		trim_s3 <= tbig_s2 ? UNITY_Q16 : COEF_BITS'(trnd >> TRIM_SH);
		x_s3    <= x_s2;
	end

	// s4: quadrant fold and table read
	assign quad = idx_s3[SB-1 -: 2];
	assign rpos = idx_s3[QBITS-1:0];
	assign mpos = quad[0] ? ((QBITS+1)'(QUARTER) - {1'b0, rpos}) : {1'b0, rpos};

	always_ff @(posedge clk) begin
		smag_s4 <= qtab[mpos];
		sneg_s4 <= quad[1];
		trim_s4 <= trim_s3;
		x_s4    <= x_s3;
	end

	// s5, s6: shaper * trim * drive
	always_ff @(posedge clk) begin
		p1_s5   <= P1_BITS'(smag_s4) * P1_BITS'(trim_s4);
		sneg_s5 <= sneg_s4;
		x_s5    <= x_s4;
		p2_s6   <= P2_BITS'(p1_s5) * P2_BITS'(cfg.drive);
		sneg_s6 <= sneg_s5;
		x_s6    <= x_s5;
	end

	// s7: delta magnitude rounded half away from zero
	assign p2r = p2_s6 + (P2_BITS'(1) << (DEL_SH - 1));

	always_ff @(posedge clk) begin
		dmag_s7 <= W'(p2r >> DEL_SH);
		sneg_s7 <= sneg_s6;
		x_s7    <= x_s6;
	end

	// s8: move toward zero, a negative shaper value flips the direction
	assign xe = (W+1)'(x_s7);
	assign de = $signed({1'b0, dmag_s7});
	assign sub_d = (!x_s7[W-1] && (x_s7 != '0)) != sneg_s7;

	always_ff @(posedge clk) begin
		y_s8 <= sub_d ? (xe - de) : (xe + de);
		x_s8 <= x_s7;
	end

	// s9, s10: output level, unity level multiplies by 1.0 exactly
	assign lr = $unsigned(lp_s9) + LP_BITS'(HALF_Q16) - LP_BITS'(lp_s9[LP_BITS-1]);

	always_ff @(posedge clk) begin
		lp_s9  <= LP_BITS'(y_s8) * LP_BITS'($signed({1'b0, cfg.level}));
		x_s9   <= x_s8;
		yl_s10 <= (W+1)'($signed(lr) >>> Q16_SH);
		x_s10  <= x_s9;
	end

	// s11 to s13: wet and dry blend, rounding and saturation
	assign mr = $unsigned(sum_s12) + LP_BITS'(HALF_Q16) - LP_BITS'(sum_s12[LP_BITS-1]);
	assign yr = $signed(mr) >>> Q16_SH;

	always_ff @(posedge clk) begin
		wp_s11  <= LP_BITS'(yl_s10) * LP_BITS'($signed({1'b0, cfg.wet}));
		dp_s11  <= LP_BITS'(x_s10) * LP_BITS'($signed({1'b0, cfg.dry}));
		sum_s12 <= wp_s11 + dp_s11;
		if (yr > SAT_HI) begin
			y_s13 <= W'(SAT_HI);
		end else if (yr < SAT_LO) begin
			y_s13 <= W'(SAT_LO);
		end else begin
			y_s13 <= W'(yr);
		end
	end

	assign y = y_s13;

endmodule

// ===== design/stereo_sine_waveshaper.sv =====
// stereo sine waveshaper top level: config registers, valid line, two channels
//
//  channel   handshake            payload
//  -------   ------------------   -------------------------------------------
//  input     start / busy         left_sample, right_sample, frame_last
//  result    done (strobe)        left_out, right_out, last_out
//  config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one frame per cycle while busy is low; each result is registered through the
// thirteen-stage channel pipeline (angle multiply, turn scaling, sine table
// read, shaper/trim/drive products, output level, wet/dry blend).
// busy is high only during reset and the first cycle after it; the pipeline
// never stalls since results cannot be held off.
// reset clears the valid line and loads the register reset values.
`include "stereo_sine_waveshaper_assert.svh"

module stereo_sine_waveshaper #(
	parameter int SAMPLE_BITS = ssw_pkg::SAMPLE_BITS_DEF,
	parameter int SINE_TABLE_BITS = ssw_pkg::SINE_TABLE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic signed [SAMPLE_BITS-1:0]     left_sample,
	input  logic signed [SAMPLE_BITS-1:0]     right_sample,
	input  logic                              frame_last,
	output logic                              done,
	output logic signed [SAMPLE_BITS-1:0]     left_out,
	output logic signed [SAMPLE_BITS-1:0]     right_out,
	output logic                              last_out,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ssw_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [ssw_pkg::COEF_BITS-1:0]     cfg_data
);
	import ssw_pkg::*;

	logic                   busy_q;
	logic [COEF_BITS-1:0]   drive_q, level_q, wet_q;
	logic [PIPE_DEPTH-1:0]  vld_q;
	logic [PIPE_DEPTH-1:0]  last_q;
	logic                   accept;
	cfg_t                   cfg;

	assign accept    = start && !busy_q;
	assign busy      = busy_q;
	assign cfg_ready = !busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b1;
			drive_q <= DRIVE_RST;
			level_q <= LEVEL_RST;
			wet_q   <= WET_RST;
		end else begin
			busy_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_DRIVE: drive_q <= cfg_data;
					REG_LEVEL: level_q <= cfg_data;
					REG_WET:   wet_q   <= cfg_data;
					default:   ;
				endcase
			end
		end
	end

	// level and wet at or above unity become exactly unity
	always_comb begin
		cfg.drive = drive_q;
		cfg.gain  = GAIN_BITS'({drive_q, 2'b00}) + GAIN_OFFSET_Q16;
		cfg.level = (level_q >= UNITY_Q16) ? UNITY_Q16 : level_q;
		cfg.wet   = (wet_q >= UNITY_Q16) ? UNITY_Q16 : wet_q;
		cfg.dry   = UNITY_Q16 - cfg.wet;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[PIPE_DEPTH-2:0], accept};
		end
	end

	always_ff @(posedge clk) begin
		last_q <= {last_q[PIPE_DEPTH-2:0], frame_last};
	end

	assign done     = vld_q[PIPE_DEPTH-1];
	assign last_out = last_q[PIPE_DEPTH-1];

	ssw_channel #(
		.SAMPLE_BITS     (SAMPLE_BITS),
		.SINE_TABLE_BITS (SINE_TABLE_BITS)
	) u_left (
		.clk (clk),
		.cfg (cfg),
		.x   (left_sample),
		.y   (left_out)
	);

	ssw_channel #(
		.SAMPLE_BITS     (SAMPLE_BITS),
		.SINE_TABLE_BITS (SINE_TABLE_BITS)
	) u_right (
		.clk (clk),
		.cfg (cfg),
		.x   (right_sample),
		.y   (right_out)
	);

	`SSW_ASSERT(a_done_has_item, clk, arst_n, done |-> $past(start && !busy, PIPE_DEPTH), "result strobe without an accepted item")
	`SSW_ASSERT(a_zero_passes, clk, arst_n, (start && !busy && left_sample == '0) |-> ##PIPE_DEPTH (left_out == '0), "zero left sample did not give zero")
	`SSW_ASSERT(a_dry_only, clk, arst_n, (start && !busy && wet_q == '0) |-> ##PIPE_DEPTH (right_out == $past(right_sample, PIPE_DEPTH)), "dry-only mix changed the right sample")
	`SSW_ASSERT_ALWAYS(a_reset_flush, clk, !arst_n |=> (!done && busy), "pipeline not flushed by reset")

endmodule
